FILE: design/sdtp_pkg.sv
// Package: phase encoding, status codes, element and alphabet codes and record type for the TPDU header parser.
package sdtp_pkg;

    localparam logic [7:0] MAX_TPDU_BYTES = 8'd255;

    localparam logic [7:0] IE_CONCAT8  = 8'h00;
    localparam logic [7:0] IE_CONCAT16 = 8'h08;
    localparam logic [7:0] IE_SHIFT1   = 8'h24;
    localparam logic [7:0] IE_SHIFTL   = 8'h25;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_ADDR      = 3'd2;
    localparam logic [2:0] ST_CODING    = 3'd3;
    localparam logic [2:0] ST_BINARY    = 3'd4;
    localparam logic [2:0] ST_LENGTH    = 3'd5;
    localparam logic [2:0] ST_HEADER    = 3'd6;

    localparam logic [1:0] ALPH_GSM7 = 2'd0;
    localparam logic [1:0] ALPH_8BIT = 2'd1;
    localparam logic [1:0] ALPH_UCS2 = 2'd2;

    typedef enum logic [11:0] {
        PH_IDLE  = 12'b0000_0000_0001,
        PH_TOA   = 12'b0000_0000_0010,
        PH_ADDR  = 12'b0000_0000_0100,
        PH_PID   = 12'b0000_0000_1000,
        PH_DCS   = 12'b0000_0001_0000,
        PH_TS    = 12'b0000_0010_0000,
        PH_UDL   = 12'b0000_0100_0000,
        PH_UDHL  = 12'b0000_1000_0000,
        PH_ETYPE = 12'b0001_0000_0000,
        PH_ELEN  = 12'b0010_0000_0000,
        PH_EDATA = 12'b0100_0000_0000,
        PH_PAD   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]  septet_padding;
        logic [8:0]  body_units;
        logic [7:0]  body_offset;
        logic [7:0]  locking_shift;
        logic [7:0]  single_shift;
        logic [7:0]  part_number;
        logic [7:0]  total_parts;
        logic [15:0] concat_ref;
        logic [7:0]  address_digits;
        logic [7:0]  address_type;
        logic [1:0]  alphabet;
        logic [2:0]  status;
    } record_t;

endpackage

FILE: design/sms_deliver_tpdu_header_parser.sv
// Top level: SMS-DELIVER TPDU header parser, one octet word per cycle while s_axis_tready is high.
// A record appears on m_ in the cycle after the octet word that decides it is accepted.
// Throughput: one octet word per cycle; the single output register refills in the
// cycle it is emptied, so s_axis_tready follows m_axis_tready or an empty output.
// Reset: aresetn synchronous active low; returns to idle, clears the output valid
// and all per-TPDU state (total parts held at one).
module sms_deliver_tpdu_header_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
    input  logic [9:0]   s_axis_tuser,   // [0] start_flag, [8:1] pdu_length, [9] header_flag
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // status, alphabet, address_type, address_digits,
                                         // concat_ref, total_parts, part_number,
                                         // single_shift, locking_shift, body_offset,
                                         // body_units, septet_padding; zero fill above
);
    import sdtp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic        hflag_reg, hflag_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  atype_reg, atype_next;
    logic [7:0]  adig_reg, adig_next;
    logic [1:0]  alph_reg, alph_next;
    logic [7:0]  hrem_reg, hrem_next;
    logic [7:0]  etype_reg, etype_next;
    logic [7:0]  eleft_reg, eleft_next;
    logic [15:0] ref_reg, ref_next;
    logic [7:0]  parts_reg, parts_next;
    logic [7:0]  order_reg, order_next;
    logic [7:0]  ss_reg, ss_next;
    logic [7:0]  ls_reg, ls_next;
    logic [9:0]  nib_reg, nib_next;
    logic [2:0]  pad_reg, pad_next;

    record_t     rec_reg, rec;
    logic        out_valid_reg;
    logic        emit;
    logic [2:0]  st;
    logic        accept;

    logic [7:0]  b;
    logic        start;
    logic [7:0]  slen;
    logic [8:0]  ab;
    logic [7:0]  idx_inc;
    logic [8:0]  nxt;
    logic [7:0]  after;     // octets left after the current one
    logic [3:0]  dcs_hi;
    logic [1:0]  dcs_a;
    logic [10:0] nib_calc;
    logic [9:0]  ud_bytes;
    logic [9:0]  sub;
    logic [7:0]  hrem_dec;
    logic [4:0]  m7_s1;     // octal digit sum of the octet, same residue mod 7
    logic [3:0]  m7_s2;
    logic [2:0]  udhl_mod7;

    assign b      = s_axis_tdata;
    assign start  = s_axis_tuser[0];
    assign slen   = s_axis_tuser[8:1];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    assign ab      = ({1'b0, b} + 9'd1) >> 1;
    assign idx_inc = idx_reg + 8'd1;
    // index after this octet is idx_inc; octets after it
    assign nxt     = {1'b0, idx_inc} + 9'd1;
    assign after   = ({1'b0, len_reg} >= nxt) ? 8'({1'b0, len_reg} - nxt) : 8'd0;
    assign dcs_hi  = b[7:4];
    assign dcs_a   = b[3:2];
    assign nib_calc = 11'(({3'b0, b} * 11'd7 + 11'd3) >> 2);
    assign sub      = 10'(({2'b0, b} + 10'd1) << 1);
    assign hrem_dec = hrem_reg - 8'd1;

    // header length mod 7: eight is one mod 7, so fold octal digits twice
    assign m7_s1     = {2'b0, b[2:0]} + {2'b0, b[5:3]} + {3'b0, b[7:6]};
    assign m7_s2     = {1'b0, m7_s1[2:0]} + {2'b0, m7_s1[4:3]};
    assign udhl_mod7 = (m7_s2 >= 4'd7) ? 3'(m7_s2 - 4'd7) : m7_s2[2:0];

    // close a header element: done when nothing is left, else next element or pad
    function automatic logic next_elem(input logic [7:0] rem, output phase_t ph);
        ph = (rem >= 8'd2) ? PH_ETYPE : PH_PAD;
        return (rem == 8'd0);
    endfunction

    always_comb begin
        phase_t ph_tmp;
        logic   done;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        hflag_next = hflag_reg;
        skip_next  = skip_reg;
        atype_next = atype_reg;
        adig_next  = adig_reg;
        alph_next  = alph_reg;
        hrem_next  = hrem_reg;
        etype_next = etype_reg;
        eleft_next = eleft_reg;
        ref_next   = ref_reg;
        parts_next = parts_reg;
        order_next = order_reg;
        ss_next    = ss_reg;
        ls_next    = ls_reg;
        nib_next   = nib_reg;
        pad_next   = pad_reg;
        emit       = 1'b0;
        st         = ST_OK;
        ud_bytes   = 10'd0;
        ph_tmp     = PH_IDLE;
        done       = 1'b0;

        if (start) begin
            // fresh TPDU: reload everything from the start octet
            idx_next   = 8'd0;
            alph_next  = ALPH_GSM7;
            atype_next = 8'd0;
            hrem_next  = 8'd0;
            etype_next = 8'd0;
            eleft_next = 8'd0;
            ref_next   = 16'd0;
            parts_next = 8'd1;
            order_next = 8'd0;
            ss_next    = 8'd0;
            ls_next    = 8'd0;
            nib_next   = 10'd0;
            pad_next   = 3'd0;
            len_next   = slen;
            hflag_next = s_axis_tuser[9];
            adig_next  = b;
            skip_next  = ab[7:0];
            phase_next = PH_TOA;
            if (slen > MAX_TPDU_BYTES) begin
                emit = 1'b1; st = ST_LENGTH;
            end else if (slen == 8'd0) begin
                emit = 1'b1; st = ST_TRUNC;
            end else if (slen < 8'd2 || ab > ({1'b0, slen} - 9'd2)) begin
                emit = 1'b1; st = ST_ADDR;
            end else if ((ab + 9'd12) > {1'b0, slen}) begin
                emit = 1'b1; st = ST_TRUNC;
            end
        end else if (phase_reg != PH_IDLE) begin
            idx_next = idx_inc;
            case (phase_reg)
                PH_TOA: begin
                    atype_next = b;
                    phase_next = (skip_reg != 8'd0) ? PH_ADDR : PH_PID;
                end
                PH_ADDR: begin
                    skip_next = (skip_reg != 8'd0) ? skip_reg - 8'd1 : 8'd0;
                    if (skip_next == 8'd0) phase_next = PH_PID;
                end
                PH_PID: phase_next = PH_DCS;
                PH_DCS: begin
                    if (dcs_hi == 4'h0 || dcs_hi == 4'h1 || dcs_hi == 4'h4 ||
                        dcs_hi == 4'h5 || dcs_hi == 4'hF) begin
                        if (dcs_a == 2'd3) begin
                            emit = 1'b1; st = ST_CODING;
                        end else if (dcs_a == ALPH_8BIT) begin
                            emit = 1'b1; st = ST_BINARY;
                        end else begin
                            alph_next = dcs_a; skip_next = 8'd7; phase_next = PH_TS;
                        end
                    end else if (dcs_hi == 4'hC || dcs_hi == 4'hD) begin
                        if (b[2]) begin
                            emit = 1'b1; st = ST_CODING;
                        end else begin
                            alph_next = ALPH_GSM7; skip_next = 8'd7; phase_next = PH_TS;
                        end
                    end else begin
                        emit = 1'b1; st = ST_CODING;
                    end
                end
                PH_TS: begin
                    skip_next = (skip_reg != 8'd0) ? skip_reg - 8'd1 : 8'd0;
                    if (skip_next == 8'd0) phase_next = PH_UDL;
                end
                PH_UDL: begin
                    ud_bytes = {2'b0, b};
                    if (alph_reg == ALPH_GSM7) begin
                        nib_next = nib_calc[9:0];
                        ud_bytes = 10'((nib_calc + 11'd1) >> 1);
                    end
                    if (ud_bytes != {2'b0, after}) begin
                        emit = 1'b1; st = ST_LENGTH;
                    end else if (hflag_reg) begin
                        if (after == 8'd0) begin
                            emit = 1'b1; st = ST_HEADER;
                        end else begin
                            phase_next = PH_UDHL;
                        end
                    end else begin
                        emit = 1'b1; st = ST_OK;
                    end
                end
                PH_UDHL: begin
                    if (alph_reg == ALPH_GSM7) begin
                        pad_next = 3'd6 - udhl_mod7;
                        nib_next = (nib_reg > sub) ? nib_reg - sub : 10'd0;
                    end
                    if (after < b) begin
                        emit = 1'b1; st = ST_HEADER;
                    end else begin
                        hrem_next = b;
                        done = next_elem(b, ph_tmp);
                        if (done) begin
                            emit = 1'b1; st = ST_OK;
                        end else begin
                            phase_next = ph_tmp;
                        end
                    end
                end
                PH_ETYPE: begin
                    etype_next = b;
                    hrem_next  = hrem_dec;
                    phase_next = PH_ELEN;
                end
                PH_ELEN: begin
                    hrem_next = hrem_dec;
                    if (b > hrem_dec ||
                        (etype_reg == IE_CONCAT8 && b != 8'd3) ||
                        (etype_reg == IE_CONCAT16 && b != 8'd4) ||
                        ((etype_reg == IE_SHIFT1 || etype_reg == IE_SHIFTL) &&
                         b != 8'd1)) begin
                        emit = 1'b1; st = ST_HEADER;
                    end else begin
                        eleft_next = b;
                        if (b == 8'd0) begin
                            done = next_elem(hrem_dec, ph_tmp);
                            if (done) begin
                                emit = 1'b1; st = ST_OK;
                            end else begin
                                phase_next = ph_tmp;
                            end
                        end else begin
                            phase_next = PH_EDATA;
                        end
                    end
                end
                PH_EDATA: begin
                    if (etype_reg == IE_CONCAT8) begin
                        if (eleft_reg == 8'd3) ref_next = {8'd0, b};
                        else if (eleft_reg == 8'd2) parts_next = b;
                        else if (eleft_reg == 8'd1) order_next = b;
                    end else if (etype_reg == IE_CONCAT16) begin
                        if (eleft_reg == 8'd4) ref_next = {b, 8'd0};
                        else if (eleft_reg == 8'd3) ref_next = ref_reg | {8'd0, b};
                        else if (eleft_reg == 8'd2) parts_next = b;
                        else if (eleft_reg == 8'd1) order_next = b;
                    end else if (etype_reg == IE_SHIFT1) begin
                        ss_next = b;
                    end else if (etype_reg == IE_SHIFTL) begin
                        ls_next = b;
                    end
                    hrem_next  = (hrem_reg != 8'd0) ? hrem_dec : 8'd0;
                    eleft_next = (eleft_reg != 8'd0) ? eleft_reg - 8'd1 : 8'd0;
                    if (eleft_next == 8'd0) begin
                        done = next_elem(hrem_next, ph_tmp);
                        if (done) begin
                            emit = 1'b1; st = ST_OK;
                        end else begin
                            phase_next = ph_tmp;
                        end
                    end
                end
                PH_PAD: begin
                    hrem_next = 8'd0;
                    emit = 1'b1; st = ST_OK;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        if (emit) phase_next = PH_IDLE;
    end

    // build the record from the state as it stands after this octet
    always_comb begin
        rec = '0;
        rec.status = st;
        if (st == ST_OK) begin
            rec.alphabet       = alph_next;
            rec.address_type   = atype_next;
            rec.address_digits = adig_next;
            rec.concat_ref     = ref_next;
            rec.total_parts    = parts_next;
            rec.part_number    = order_next;
            rec.single_shift   = ss_next;
            rec.locking_shift  = ls_next;
            rec.body_offset    = idx_next + 8'd1;
            rec.body_units     = (alph_next == ALPH_GSM7) ? nib_next[8:0] : {1'b0, after};
            rec.septet_padding = pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= 8'd0;
            len_reg       <= 8'd0;
            hflag_reg     <= 1'b0;
            skip_reg      <= 8'd0;
            atype_reg     <= 8'd0;
            adig_reg      <= 8'd0;
            alph_reg      <= 2'd0;
            hrem_reg      <= 8'd0;
            etype_reg     <= 8'd0;
            eleft_reg     <= 8'd0;
            ref_reg       <= 16'd0;
            parts_reg     <= 8'd1;
            order_reg     <= 8'd0;
            ss_reg        <= 8'd0;
            ls_reg        <= 8'd0;
            nib_reg       <= 10'd0;
            pad_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            // load on an emitting word, hold while the record waits, else drop
            out_valid_reg <= (accept && emit) || (out_valid_reg && !m_axis_tready);
            if (accept) begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                len_reg   <= len_next;
                hflag_reg <= hflag_next;
                skip_reg  <= skip_next;
                atype_reg <= atype_next;
                adig_reg  <= adig_next;
                alph_reg  <= alph_next;
                hrem_reg  <= hrem_next;
                etype_reg <= etype_next;
                eleft_reg <= eleft_next;
                ref_reg   <= ref_next;
                parts_reg <= parts_next;
                order_reg <= order_next;
                ss_reg    <= ss_next;
                ls_reg    <= ls_next;
                nib_reg   <= nib_next;
                pad_reg   <= pad_next;
            end
        end
    end

    // hold the record while it waits; load a new one on an emitting word
    always_ff @(posedge aclk) begin
        if (accept && emit) rec_reg <= rec;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, rec_reg};

endmodule

FILE: dv/sdtp_checker.sv
// Checker: predicts the parser's record for each TPDU and compares it with the m_ side.
module sdtp_checker
    import sdtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [9:0]  s_axis_tuser,   // [0] start_flag, [8:1] pdu_length, [9] header_flag
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,   // record_t fields from status upward
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t      phase;
    logic [7:0]  idx, pdu_len, skip, toa, digits, udl, hdr_left, ie_type, ie_left;
    logic [7:0]  parts, order, shift_single, shift_locking;
    logic        hdr_flag;
    logic [1:0]  alph;
    logic [15:0] cref;
    logic [9:0]  nibbles;
    logic [2:0]  padding;
    record_t     record_q[$];

    function automatic int octets_after();
        int nxt;
        nxt = int'(idx) + 1;
        return (int'(pdu_len) >= nxt) ? int'(pdu_len) - nxt : 0;
    endfunction

    task automatic clear_tpdu();
        idx = 0; skip = 0; toa = 0; digits = 0; alph = ALPH_GSM7; udl = 0;
        hdr_left = 0; ie_type = 0; ie_left = 0; cref = 0; parts = 1; order = 0;
        shift_single = 0; shift_locking = 0; nibbles = 0; padding = 0;
    endtask

    // Returns 1 when the header walk is finished (record due).
    function automatic bit next_element();
        if (hdr_left == 0) return 1'b1;
        phase = (hdr_left >= 2) ? PH_ETYPE : PH_PAD;
        return 1'b0;
    endfunction

    task automatic parse_octet(input logic [7:0] b, input logic [9:0] user);
        bit         emit;
        logic [2:0] st;
        int         len, ab, rem, nbytes, nib, sub;
        logic [3:0] grp;
        record_t    r;
        emit = 0;
        st = ST_OK;
        if (user[0]) begin
            len = int'(user[8:1]);
            ab = (int'(b) + 1) >> 1;
            clear_tpdu();
            pdu_len = user[8:1];
            hdr_flag = user[9];
            digits = b;
            phase = PH_TOA;
            skip = ab[7:0];
            if (len > int'(MAX_TPDU_BYTES)) begin emit = 1; st = ST_LENGTH; end
            else if (len == 0) begin emit = 1; st = ST_TRUNC; end
            else if (len < 2 || ab > len - 2) begin emit = 1; st = ST_ADDR; end
            else if (ab + 12 > len) begin emit = 1; st = ST_TRUNC; end
        end else begin
            if (phase == PH_IDLE) return;
            idx = idx + 8'd1;
            case (phase)
                PH_TOA: begin
                    toa = b;
                    phase = (skip != 0) ? PH_ADDR : PH_PID;
                end
                PH_ADDR: begin
                    if (skip != 0) skip = skip - 8'd1;
                    if (skip == 0) phase = PH_PID;
                end
                PH_PID: phase = PH_DCS;
                PH_DCS: begin
                    grp = b[7:4];
                    if (grp inside {4'h0, 4'h1, 4'h4, 4'h5, 4'hF}) begin
                        if (b[3:2] == 2'd3) begin emit = 1; st = ST_CODING; end
                        else if (b[3:2] == ALPH_8BIT) begin emit = 1; st = ST_BINARY; end
                        else alph = b[3:2];
                    end else if (grp == 4'hC || grp == 4'hD) begin
                        if (b[2]) begin emit = 1; st = ST_CODING; end
                        else alph = ALPH_GSM7;
                    end else begin
                        emit = 1; st = ST_CODING;
                    end
                    if (!emit) begin
                        skip = 8'd7;
                        phase = PH_TS;
                    end
                end
                PH_TS: begin
                    if (skip != 0) skip = skip - 8'd1;
                    if (skip == 0) phase = PH_UDL;
                end
                PH_UDL: begin
                    rem = octets_after();
                    nbytes = int'(b);
                    udl = b;
                    if (alph == ALPH_GSM7) begin
                        nib = (int'(b) * 7 + 3) / 4;
                        nibbles = nib[9:0];
                        nbytes = (nib + 1) / 2;
                    end
                    if (nbytes != rem) begin emit = 1; st = ST_LENGTH; end
                    else if (hdr_flag) begin
                        if (rem == 0) begin emit = 1; st = ST_HEADER; end
                        else phase = PH_UDHL;
                    end else emit = 1;
                end
                PH_UDHL: begin
                    if (alph == ALPH_GSM7) begin
                        sub = (int'(b) + 1) * 2;
                        padding = 3'(6 - (int'(b) % 7));
                        nibbles = (int'(nibbles) > sub) ? 10'(int'(nibbles) - sub) : 10'd0;
                    end
                    if (octets_after() < int'(b)) begin emit = 1; st = ST_HEADER; end
                    else begin
                        hdr_left = b;
                        emit = next_element();
                    end
                end
                PH_ETYPE: begin
                    ie_type = b;
                    hdr_left = hdr_left - 8'd1;
                    phase = PH_ELEN;
                end
                PH_ELEN: begin
                    hdr_left = hdr_left - 8'd1;
                    if (b > hdr_left ||
                        (ie_type == IE_CONCAT8 && b != 8'd3) ||
                        (ie_type == IE_CONCAT16 && b != 8'd4) ||
                        ((ie_type == IE_SHIFT1 || ie_type == IE_SHIFTL) && b != 8'd1)) begin
                        emit = 1; st = ST_HEADER;
                    end else begin
                        ie_left = b;
                        if (b == 0) emit = next_element();
                        else phase = PH_EDATA;
                    end
                end
                PH_EDATA: begin
                    if (ie_type == IE_CONCAT8) begin
                        if (ie_left == 3) cref = {8'd0, b};
                        else if (ie_left == 2) parts = b;
                        else if (ie_left == 1) order = b;
                    end else if (ie_type == IE_CONCAT16) begin
                        if (ie_left == 4) cref = {b, 8'd0};
                        else if (ie_left == 3) cref = cref | {8'd0, b};
                        else if (ie_left == 2) parts = b;
                        else if (ie_left == 1) order = b;
                    end else if (ie_type == IE_SHIFT1) shift_single = b;
                    else if (ie_type == IE_SHIFTL) shift_locking = b;
                    if (hdr_left != 0) hdr_left = hdr_left - 8'd1;
                    if (ie_left != 0) ie_left = ie_left - 8'd1;
                    if (ie_left == 0) emit = next_element();
                end
                PH_PAD: begin
                    hdr_left = 0;
                    emit = 1;
                end
                default: phase = PH_IDLE;
            endcase
        end
        if (!emit) return;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.alphabet = alph;
            r.address_type = toa;
            r.address_digits = digits;
            r.concat_ref = cref;
            r.total_parts = parts;
            r.part_number = order;
            r.single_shift = shift_single;
            r.locking_shift = shift_locking;
            r.body_offset = idx + 8'd1;
            r.body_units = (alph == ALPH_GSM7) ? nibbles[8:0] : 9'(octets_after());
            r.septet_padding = padding;
        end
        record_q.push_back(r);
        phase = PH_IDLE;
    endtask

    always @(posedge aclk) begin
        record_t want, got;
        if (!aresetn) begin
            errors = 0;
            phase = PH_IDLE;
            pdu_len = 0;
            hdr_flag = 0;
            clear_tpdu();
            record_q.delete();
        end else begin
            // Compare the returning record first: it belongs to an earlier octet word.
            if (m_axis_tvalid && m_axis_tready) begin
                if (record_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected record %h", m_axis_tdata);
                end else begin
                    want = record_q.pop_front();
                    got = m_axis_tdata[88:0];
                    if ({7'd0, want} !== m_axis_tdata) begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: record mismatch exp st=%0d al=%0d toa=%h dg=%0d ",
                                      "ref=%h tp=%0d pn=%0d ss=%0d ls=%0d off=%0d bu=%0d pad=%0d ",
                                      "got st=%0d al=%0d toa=%h dg=%0d ref=%h tp=%0d pn=%0d ",
                                      "ss=%0d ls=%0d off=%0d bu=%0d pad=%0d"},
                                     want.status, want.alphabet, want.address_type,
                                     want.address_digits, want.concat_ref, want.total_parts,
                                     want.part_number, want.single_shift, want.locking_shift,
                                     want.body_offset, want.body_units, want.septet_padding,
                                     got.status, got.alphabet, got.address_type,
                                     got.address_digits, got.concat_ref, got.total_parts,
                                     got.part_number, got.single_shift, got.locking_shift,
                                     got.body_offset, got.body_units, got.septet_padding);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_octet(s_axis_tdata, s_axis_tuser);
        end
        pending = record_q.size();
    end

endmodule

FILE: dv/tb.sv
// Testbench top: drives TPDU octet words into the parser and reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdtp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_WORDS = 1900;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] byte_value
    logic [9:0]  s_axis_tuser;   // [0] start_flag, [8:1] pdu_length, [9] header_flag
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [95:0] m_axis_tdata;   // status, alphabet, address_type, address_digits, concat_ref,
                                 // total_parts, part_number, single_shift, locking_shift,
                                 // body_offset, body_units, septet_padding
    int          errors;
    int          pending;
    int          cycles = 0;
    int          words_sent;
    bit          tx_burst;
    bit          rx_burst = 1'b0;
    int          rx_wait = 0;
    logic        m_took;
    logic [7:0]  pdu[$];
    logic        pdu_hdr;
    logic [7:0]  pdu_len;

    sms_deliver_tpdu_header_parser DUT (.*);

    sdtp_checker u_checker (.*);

    // Run the clock: 5 ns high, 5 ns low.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bound the run; a hang is a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: after each accepted record hold tready low for a drawn number of cycles.
    always @(posedge aclk) m_took <= m_axis_tvalid & m_axis_tready;

    always @(negedge aclk) begin
        if (m_took) begin
            if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Send one octet word; call at a falling edge, returns at a falling edge.
    task automatic send_word(input logic [7:0] b, input logic start,
                             input logic [7:0] len, input logic hdr);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        // Off the start word the length and flag bits are ignored; toggle them anyway.
        s_axis_tuser <= start ? {hdr, len, 1'b1} : {1'($urandom), 8'($urandom), 1'b0};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Push one header element, mostly well formed.
    task automatic push_element(ref logic [7:0] hq[$]);
        int kind, n;
        kind = $urandom_range(0, 5);
        case (kind)
            0: begin
                hq.push_back(IE_CONCAT8); hq.push_back(8'd3);
                repeat (3) hq.push_back(8'($urandom));
            end
            1: begin
                hq.push_back(IE_CONCAT16); hq.push_back(8'd4);
                repeat (4) hq.push_back(8'($urandom));
            end
            2: begin
                hq.push_back(IE_SHIFT1); hq.push_back(8'd1); hq.push_back(8'($urandom));
            end
            3: begin
                hq.push_back(IE_SHIFTL); hq.push_back(8'd1); hq.push_back(8'($urandom));
            end
            default: begin
                // Unknown element: skipped by the parser.
                n = $urandom_range(0, 3);
                hq.push_back(8'($urandom_range(1, 7)));
                hq.push_back(8'(n));
                repeat (n) hq.push_back(8'($urandom));
            end
        endcase
    endtask

    // Build a TPDU into pdu; dcs_sel < 0 picks a coding at random, mostly a valid one.
    task automatic build_tpdu(input int dcs_sel, input bit corrupt);
        logic [7:0] hq[$];
        logic [7:0] dcs;
        logic [3:0] grp;
        int digits, hlen, udl, nbytes, body, pos;
        pdu.delete();
        digits = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
        pdu.push_back(8'(digits));
        pdu.push_back(8'($urandom));
        repeat ((digits + 1) / 2) pdu.push_back(8'($urandom));
        pdu.push_back(8'($urandom));
        if (dcs_sel >= 0) dcs = 8'(dcs_sel);
        else if ($urandom_range(0, 9) == 0) dcs = 8'($urandom);
        else begin
            case ($urandom_range(0, 6))
                0: grp = 4'h0;
                1: grp = 4'h1;
                2: grp = 4'h4;
                3: grp = 4'h5;
                4: grp = 4'hF;
                5: grp = 4'hC;
                default: grp = 4'hD;
            endcase
            dcs = {grp, 4'($urandom)};
            if (grp == 4'hC || grp == 4'hD) dcs[2] = 1'b0;
            else dcs[3:2] = $urandom_range(0, 1) ? ALPH_UCS2 : ALPH_GSM7;
        end
        pdu.push_back(dcs);
        repeat (7) pdu.push_back(8'($urandom));
        pdu_hdr = 1'($urandom);
        hlen = 0;
        if (pdu_hdr) begin
            repeat ($urandom_range(0, 4)) push_element(hq);
            // Trailing lone octet that cannot hold an element.
            if ($urandom_range(0, 5) == 0) hq.push_back(8'($urandom));
            hq.push_front(8'(hq.size()));
            hlen = hq.size();
        end
        if (dcs[3:2] == ALPH_UCS2 && dcs[7:4] != 4'hC && dcs[7:4] != 4'hD) begin
            udl = hlen + $urandom_range(0, 40);
            nbytes = udl;
        end else begin
            udl = $urandom_range(0, 60);
            do begin
                nbytes = (((udl * 7 + 3) / 4) + 1) / 2;
                if (nbytes < hlen) udl++;
            end while (nbytes < hlen);
        end
        pdu.push_back(8'(udl));
        foreach (hq[i]) pdu.push_back(hq[i]);
        for (body = hlen; body < nbytes; body++) pdu.push_back(8'($urandom));
        pdu_len = (pdu.size() > 255) ? 8'd255 : 8'(pdu.size());
        if (corrupt) begin
            pos = $urandom_range(1, pdu.size() - 1);
            case ($urandom_range(0, 4))
                0: pdu[pos] = 8'($urandom);
                1: pdu_len = 8'($urandom);
                2: pdu_len = pdu_len + 8'($urandom_range(1, 3)) - 8'd2;
                3: while (pdu.size() > pos) void'(pdu.pop_back());  // restart mid-TPDU
                default: repeat ($urandom_range(1, 4)) pdu.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic send_tpdu();
        foreach (pdu[i]) send_word(pdu[i], i == 0, pdu_len, pdu_hdr);
    endtask

    initial begin
        logic [7:0] dcs_list[8];
        dcs_list = '{8'h00, 8'h04, 8'h08, 8'h0C, 8'hC4, 8'hD0, 8'h20, 8'hF8};
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        tx_burst = 0;
        words_sent = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: a stray octet while idle, zero length, address overrun, truncation, each coding class.
        send_word(8'hFF, 1'b0, 8'h00, 1'b0);
        send_word(8'h00, 1'b1, 8'd0, 1'b0);
        send_word(8'hFF, 1'b1, 8'd100, 1'b1);
        send_word(8'h00, 1'b1, 8'd255, 1'b1);
        send_word(8'h04, 1'b1, 8'd13, 1'b0);
        foreach (dcs_list[i]) begin
            build_tpdu(dcs_list[i], 1'b0);
            send_tpdu();
        end

        // Random: mostly well-formed TPDUs, a quarter damaged.
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 7) == 0) tx_burst = ~tx_burst;
            build_tpdu(-1, $urandom_range(0, 3) == 0);
            send_tpdu();
            // Drain once mid-run before sending on.
            if (words_sent > RANDOM_WORDS / 2 && words_sent - pdu.size() <= RANDOM_WORDS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then let the registered output settle.
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sms_deliver_tpdu_header_parser.f
design/sdtp_pkg.sv
design/sms_deliver_tpdu_header_parser.sv
dv/sdtp_checker.sv
dv/tb.sv
